[hdl/spc_pkg.sv]
// Shared types and constants for the stepper position and homing controller.
// No dependencies.
`timescale 1ns / 1ps

package spc_pkg;

  localparam int FIELD_W     = 24;
  localparam int OPCODE_W    = 3;
  localparam int PRESCALE_W  = 10;
  localparam int PERIOD_W    = 16;
  localparam int PSEL_W      = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 3'd0,
    OP_POLL     = 3'd1,
    OP_HOME     = 3'd2,
    OP_ZERO     = 3'd3,
    OP_SETPOINT = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    HOME_TRACK = 2'd0,
    HOME_SEEK  = 2'd1,
    HOME_LEAVE = 2'd2
  } homing_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SEEK_LOAD = 2'd0,
    CFG_PRESCALE  = 2'd1,
    CFG_COMPARE   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] seek_load_pos;
    logic [PSEL_W-1:0]         prescale_sel;
    logic [PERIOD_W-1:0]       compare_val;
  } cfg_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic                      reference_switch;
    logic signed [FIELD_W-1:0] setpoint_value;
  } in_item_t;

  typedef struct packed {
    logic                      step_pulse;
    logic                      direction_level;
    logic                      moving_flag;
    logic                      busy_res;
    logic signed [FIELD_W-1:0] current_position;
    logic [1:0]                homing_phase;
  } out_item_t;

  function automatic logic [PRESCALE_W:0] prescale_divisor(input logic [PSEL_W-1:0] sel);
    logic [PRESCALE_W:0] div;
    case (sel)
      3'd0:    div = 11'd1;
      3'd1:    div = 11'd8;
      3'd2:    div = 11'd64;
      3'd3:    div = 11'd256;
      default: div = 11'd1024;
    endcase
    return div;
  endfunction

endpackage

[hdl/spc_in_if.sv]
// Command channel interface: valid/ready handshake with one command transaction.
// Depends on spc_pkg.
`timescale 1ns / 1ps

interface spc_in_if import spc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic                      reference_switch;
  logic signed [FIELD_W-1:0] setpoint_value;

  modport source (output valid, output opcode, output reference_switch,
                  output setpoint_value, input ready);
  modport sink (input valid, input opcode, input reference_switch,
                input setpoint_value, output ready);
endinterface

[hdl/spc_out_if.sv]
// Result channel interface: valid/ready handshake with one status transaction.
// Depends on spc_pkg.
`timescale 1ns / 1ps

interface spc_out_if import spc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      step_pulse;
  logic                      direction_level;
  logic                      moving_flag;
  logic                      busy_res;
  logic signed [FIELD_W-1:0] current_position;
  logic [1:0]                homing_phase;

  modport source (output valid, output step_pulse, output direction_level,
                  output moving_flag, output busy_res, output current_position,
                  output homing_phase, input ready);
  modport sink (input valid, input step_pulse, input direction_level,
                input moving_flag, input busy_res, input current_position,
                input homing_phase, output ready);
endinterface

[hdl/stepper_position_homing_controller.sv]
// Top level of the step/direction stepper controller with reference-switch homing.
// Depends on spc_pkg, spc_in_if, spc_out_if, spc_cfg and spc_core.
`timescale 1ns / 1ps

// Takes one command transaction per clock unless the result channel stalls
// and returns exactly one status transaction for each, in order. A command
// is registered on acceptance, the controller state and the status are
// computed from it combinationally, and the status is held in an output
// register until taken; throughput is one transaction per cycle, given by
// the state update between the input and output registers. Back-pressure
// on the result channel stalls the input only once both registers hold a
// transaction. Configuration writes take effect on the next clock and are
// expected while no command is in flight. POSITION_BITS sets the internal
// position counter width; the position wraps at that width and is reported
// sign-extended or truncated to 24 bits.
module stepper_position_homing_controller import spc_pkg::*; #(
  parameter int POSITION_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  spc_in_if.sink                 in_ch,
  spc_out_if.source              out_ch,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t result;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic      advance;
  logic      in_ready;

  assign advance  = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !in_valid_r || advance;

  spc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  spc_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_item_r.opcode           <= in_ch.opcode;
      in_item_r.reference_switch <= in_ch.reference_switch;
      in_item_r.setpoint_value   <= in_ch.setpoint_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.step_pulse       = out_item_r.step_pulse;
  assign out_ch.direction_level  = out_item_r.direction_level;
  assign out_ch.moving_flag      = out_item_r.moving_flag;
  assign out_ch.busy_res         = out_item_r.busy_res;
  assign out_ch.current_position = out_item_r.current_position;
  assign out_ch.homing_phase     = out_item_r.homing_phase;

endmodule

[hdl/spc_cfg.sv]
// Configuration register file: home offset, prescaler select, step compare value.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_cfg import spc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seek_load_pos <= '0;
      cfg_r.prescale_sel  <= '0;
      cfg_r.compare_val   <= '1;
    end else if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        CFG_SEEK_LOAD: cfg_r.seek_load_pos <= wr_data[FIELD_W-1:0];
        CFG_PRESCALE:  cfg_r.prescale_sel  <= wr_data[PSEL_W-1:0];
        CFG_COMPARE:   cfg_r.compare_val   <= wr_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/spc_core.sv]
// Controller state and next-state logic: step timer, homing and tracking rules.
// Depends on spc_pkg; driven by spc_cfg and the input stage of the top level.
`timescale 1ns / 1ps

module spc_core import spc_pkg::*; #(
  parameter int POSITION_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      commit,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic signed [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic signed [POSITION_BITS-1:0] tgt_r, tgt_nxt;
  logic                            motion_r, motion_nxt;
  logic                            dir_r, dir_nxt;
  homing_t                         home_r, home_nxt;
  logic [PRESCALE_W-1:0]           pre_r, pre_nxt;
  logic [PERIOD_W-1:0]             per_r, per_nxt;

  logic                            step;
  logic                            busy;
  logic                            start_req;
  logic                            start_up;
  logic [PRESCALE_W:0]             div;
  logic [PERIOD_W-1:0]             cmp;
  logic                            tracking;
  logic signed [POSITION_BITS-1:0] home_pos;
  logic signed [POSITION_BITS-1:0] set_pos;

  assign div      = prescale_divisor(cfg.prescale_sel);
  assign cmp      = (cfg.compare_val == '0) ? PERIOD_W'(1) : cfg.compare_val;
  assign tracking = (home_r != HOME_SEEK) && (home_r != HOME_LEAVE);
  assign home_pos = POSITION_BITS'(cfg.seek_load_pos);
  assign set_pos  = POSITION_BITS'(item.setpoint_value);

  always_comb begin
    pos_nxt    = pos_r;
    tgt_nxt    = tgt_r;
    motion_nxt = motion_r;
    dir_nxt    = dir_r;
    home_nxt   = home_r;
    pre_nxt    = pre_r;
    per_nxt    = per_r;
    step       = 1'b0;
    busy       = 1'b0;
    start_req  = 1'b0;
    start_up   = 1'b0;

    case (opcode_t'(item.opcode))
      OP_TICK: begin
        if (motion_r) begin
          if (({1'b0, pre_r} + 11'd1) < div) begin
            pre_nxt = pre_r + PRESCALE_W'(1);
          end else begin
            pre_nxt = '0;
            if (({1'b0, per_r} + 17'd1) < {1'b0, cmp}) begin
              per_nxt = per_r + PERIOD_W'(1);
            end else begin
              per_nxt = '0;
              if (tracking && (pos_r == tgt_r)) begin
                motion_nxt = 1'b0;
              end else begin
                step    = 1'b1;
                pos_nxt = dir_r ? pos_r + POSITION_BITS'(1) : pos_r - POSITION_BITS'(1);
              end
            end
          end
        end
      end
      OP_POLL: begin
        case (home_r)
          HOME_SEEK: begin
            if (item.reference_switch) begin
              motion_nxt = 1'b0;
              home_nxt   = HOME_TRACK;
              pos_nxt    = home_pos;
              tgt_nxt    = '0;
              busy       = (home_pos != '0);
            end else begin
              start_req = 1'b1;
              start_up  = 1'b0;
              busy      = 1'b1;
            end
          end
          HOME_LEAVE: begin
            if (item.reference_switch) begin
              start_req = 1'b1;
              start_up  = 1'b1;
            end else begin
              motion_nxt = 1'b0;
              home_nxt   = HOME_SEEK;
            end
            busy = 1'b1;
          end
          default: begin
            if (pos_r != tgt_r) begin
              start_req = 1'b1;
              start_up  = (pos_r < tgt_r);
              busy      = 1'b1;
            end else begin
              motion_nxt = 1'b0;
            end
          end
        endcase
      end
      OP_HOME: begin
        home_nxt = item.reference_switch ? HOME_LEAVE : HOME_SEEK;
      end
      OP_ZERO: begin
        pos_nxt = '0;
        tgt_nxt = '0;
      end
      OP_SETPOINT: begin
        tgt_nxt = set_pos;
        dir_nxt = (pos_r < set_pos);
      end
      default: begin
      end
    endcase

    if (start_req) begin
      dir_nxt = start_up;
      if (!motion_r) begin
        motion_nxt = 1'b1;
        pre_nxt    = '0;
        per_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      tgt_r    <= '0;
      motion_r <= 1'b0;
      dir_r    <= 1'b0;
      home_r   <= HOME_TRACK;
      pre_r    <= '0;
      per_r    <= '0;
    end else if (commit) begin
      pos_r    <= pos_nxt;
      tgt_r    <= tgt_nxt;
      motion_r <= motion_nxt;
      dir_r    <= dir_nxt;
      home_r   <= home_nxt;
      pre_r    <= pre_nxt;
      per_r    <= per_nxt;
    end
  end

  always_comb begin
    result.step_pulse       = step;
    result.direction_level  = dir_nxt;
    result.moving_flag      = motion_nxt;
    result.busy_res         = busy;
    result.current_position = FIELD_W'(pos_nxt);
    result.homing_phase     = home_nxt;
  end

endmodule

[hdl/spc_checker.sv]
// Port-level checks for the stepper controller result channel, bound to the top level.
// Depends on spc_pkg and stepper_position_homing_controller.
`timescale 1ns / 1ps

module spc_checker import spc_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      step_pulse,
  input logic                      direction_level,
  input logic                      moving_flag,
  input logic                      busy_res,
  input logic signed [FIELD_W-1:0] current_position,
  input logic [1:0]                homing_phase
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(step_pulse) && $stable(direction_level)
      && $stable(moving_flag) && $stable(busy_res) && $stable(current_position)
      && $stable(homing_phase))
    else $error("result payload changed while stalled");

  a_step_while_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && step_pulse |-> moving_flag && !busy_res)
    else $error("step issued without motion or on a poll");

endmodule

bind stepper_position_homing_controller spc_checker u_spc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .step_pulse       (out_ch.step_pulse),
  .direction_level  (out_ch.direction_level),
  .moving_flag      (out_ch.moving_flag),
  .busy_res         (out_ch.busy_res),
  .current_position (out_ch.current_position),
  .homing_phase     (out_ch.homing_phase)
);
